// ===== rtl/core/ftlb_pkg.sv =====
`default_nettype none

package ftlb_pkg;

    // Sizing of the buffer and of the page.
    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_BYTES  = 4096;

    // Address split into page number and page offset.
    localparam int ADDR_W = 32;
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int VPN_W  = ADDR_W - OFF_W;

    // Slot index and fill count widths.
    localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TLB_ENTRIES + 1);

    // Operation codes.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Request word.
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] vaddr;
        logic [ADDR_W-1:0] paddr;
    } t_tlb_req;

    // Response word.
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] phys_addr;
        logic [31:0]       hit_count;
        logic [31:0]       miss_count;
    } t_tlb_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/ftlb_ram.sv =====
`default_nettype none

module ftlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/fifo_tlb_unit.sv =====
// Insert: the entry is written on accept, and the response is registered from ST_FIN once the output is free.
// Lookup: the entries are read newest first, at most TLB_ENTRIES of them, one per cycle
// through the single read port of the entry RAM, until a hit or the oldest entry;
// a lookup on an empty buffer reads nothing and goes straight to ST_FIN.
// One request is in work at a time; a new one is taken while a response waits.
// Synchronous active-low reset clears the fill count, oldest slot, counters, phys_base
// and the handshake state; entry RAM contents are only compared within the fill range.
`default_nettype none

module fifo_tlb_unit
    import ftlb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_tlb_req i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_tlb_rsp      o_out_data,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire logic [ADDR_W-1:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FIN    = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [IDX_W-1:0]  r_oldest, n_oldest;
    logic [IDX_W-1:0]  r_k, n_k;
    logic              r_chk, n_chk;
    logic              r_chk_last, n_chk_last;
    logic              r_hit, n_hit;
    logic [VPN_W-1:0]  r_ppn, n_ppn;
    logic [ADDR_W-1:0] r_vaddr, n_vaddr;
    logic [ADDR_W-1:0] r_phys_base;
    logic [31:0]       r_hits, n_hits;
    logic [31:0]       r_misses, n_misses;
    logic              r_out_valid, n_out_valid;
    t_tlb_rsp          r_out, n_out;
    logic              r_op_lookup;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [2*VPN_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [2*VPN_W-1:0] ram_rdata;
    logic [ADDR_W-1:0] ins_diff;
    logic              in_acc;
    logic              out_free;

    // Slot of the entry with the given age, oldest being age zero.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] oldest,
                                                 input logic [IDX_W-1:0] age);
        logic [IDX_W:0] sum;
        sum = {1'b0, oldest} + {1'b0, age};
        if (sum >= (IDX_W+1)'(TLB_ENTRIES)) begin
            sum = sum - (IDX_W+1)'(TLB_ENTRIES);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign ins_diff    = i_in_data.paddr - r_phys_base;
    assign ram_raddr   = slot_of(r_oldest, r_k);

    // Entry RAM: each word holds the virtual page over the physical page relative to phys_base.
    ftlb_ram #(
        .WIDTH (2 * VPN_W),
        .DEPTH (TLB_ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer: accept, for a lookup walk the entries newest first, then post the response.
    // Only one request is in work, so a write never overlaps a search over the entries.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_oldest    = r_oldest;
        n_k         = r_k;
        n_chk       = r_chk;
        n_chk_last  = r_chk_last;
        n_hit       = r_hit;
        n_ppn       = r_ppn;
        n_vaddr     = r_vaddr;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_oldest;
        ram_wdata   = {i_in_data.vaddr[ADDR_W-1:OFF_W], ins_diff[ADDR_W-1:OFF_W]};

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_vaddr = i_in_data.vaddr;
                    n_hit   = 1'b0;
                    n_chk   = 1'b0;
                    if (i_in_data.op == OP_INSERT) begin
                        ram_we  = 1'b1;
                        n_state = ST_FIN;
                        if (r_fill == CNT_W'(TLB_ENTRIES)) begin
                            ram_waddr = r_oldest;
                            n_oldest  = (r_oldest == IDX_W'(TLB_ENTRIES - 1)) ?
                                        '0 : r_oldest + 1'b1;
                        end else begin
                            ram_waddr = slot_of(r_oldest, r_fill[IDX_W-1:0]);
                            n_fill    = r_fill + 1'b1;
                        end
                    end else if (r_fill == '0) begin
                        n_state = ST_FIN;
                    end else begin
                        n_k     = r_fill[IDX_W-1:0] - 1'b1;
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                // Issue the read for the current age and check the previous one.
                n_chk      = 1'b1;
                n_chk_last = (r_k == '0);
                if (r_k != '0) begin
                    n_k = r_k - 1'b1;
                end
                if (r_chk) begin
                    if (ram_rdata[2*VPN_W-1:VPN_W] == r_vaddr[ADDR_W-1:OFF_W]) begin
                        n_hit   = 1'b1;
                        n_ppn   = ram_rdata[VPN_W-1:0];
                        n_state = ST_FIN;
                    end else if (r_chk_last) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out.hit        = r_hit;
                    n_out.phys_addr  = r_hit ?
                                       r_phys_base + {r_ppn, r_vaddr[OFF_W-1:0]} : '0;
                    n_out.hit_count  = r_hits;
                    n_out.miss_count = r_misses;
                    if (r_op_lookup) begin
                        if (r_hit) begin
                            if (r_hits != '1) begin
                                n_hits = r_hits + 1'b1;
                            end
                            n_out.hit_count = n_hits;
                        end else begin
                            if (r_misses != '1) begin
                                n_misses = r_misses + 1'b1;
                            end
                            n_out.miss_count = n_misses;
                        end
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Operation of the request in work.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op_lookup <= (i_in_data.op == OP_LOOKUP);
        end
    end

    // Control and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_oldest    <= '0;
            r_chk       <= 1'b0;
            r_chk_last  <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
            r_phys_base <= '0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_oldest    <= n_oldest;
            r_chk       <= n_chk;
            r_chk_last  <= n_chk_last;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_phys_base <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_hit   <= n_hit;
        r_ppn   <= n_ppn;
        r_vaddr <= n_vaddr;
        r_out   <= n_out;
    end

    // The fill count never exceeds the number of slots.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(TLB_ENTRIES))
        else $error("fill count above capacity");

    // The oldest slot only moves once the buffer is full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest != '0) |-> (r_fill == CNT_W'(TLB_ENTRIES)))
        else $error("oldest slot moved before the buffer filled");

    // A search only runs over a nonempty buffer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_fill != '0))
        else $error("search over an empty buffer");

    // After an accept, no further request is taken in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("request taken while one is in work");

    // A response without a hit carries a zero address.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hit) |-> (o_out_data.phys_addr == '0))
        else $error("miss response carries an address");

endmodule

`default_nettype wire
